// ===== hdl/rrip_pkg.sv =====
// shared types, constants and codes of the adaptive rrip replacement block
`timescale 1ns / 1ps

package rrip_pkg;

  localparam int unsigned SETS  = 64;
  localparam int unsigned WAYS  = 8;
  localparam int unsigned PAGES = 4096;

  localparam int unsigned SET_W   = $clog2(SETS);
  localparam int unsigned WAY_W   = $clog2(WAYS);
  localparam int unsigned PAGE_W  = $clog2(PAGES);
  localparam int unsigned RRPV_W  = 4;
  localparam int unsigned CNT_W   = 18;
  localparam int unsigned SEL_W   = 7;
  localparam int unsigned PCNT_W  = 8;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CNT_W-1:0]  TRAIN_RESET  = CNT_W'(200000);
  localparam logic [CNT_W-1:0]  COUNT_SAT    = '1;
  localparam logic [SEL_W-1:0]  SEL_MAX      = SEL_W'(100);
  localparam logic [SEL_W-1:0]  SEL_START    = SEL_W'(50);
  localparam logic [SEL_W-1:0]  SEL_ITP_LOW  = SEL_W'(60);
  localparam logic [SEL_W-1:0]  SEL_DTP_HIGH = SEL_W'(40);
  // page counts are held as plain use counts, so a new page reads as zero
  localparam logic [PCNT_W-1:0] PAGE_HOT     = PCNT_W'(52);
  localparam logic [PCNT_W-1:0] PAGE_SAT     = '1;
  localparam logic [RRPV_W-1:0] MAX_RRPV_RESET = RRPV_W'(3);

  // request opcodes
  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_VICTIM = 1'b1;

  // policy codes reported with each result
  localparam logic [1:0] POL_SRRIP  = 2'd0;
  localparam logic [1:0] POL_ITP    = 2'd1;
  localparam logic [1:0] POL_DTP    = 2'd2;
  localparam logic [1:0] POL_VICTIM = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RRPV  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INSTR_POS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_POS  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TRAINING  = 2'd3;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } rrip_state_e;

  typedef logic [WAYS-1:0][RRPV_W-1:0] rrip_row_t;

  typedef struct packed {
    logic              op;
    logic [SET_W-1:0]  set_index;
    logic [WAY_W-1:0]  way_index;
    logic              is_hit;
    logic              is_instruction;
    logic [PAGE_W-1:0] page_number;
  } rrip_in_t;

  typedef struct packed {
    logic [WAY_W-1:0]  victim_way;
    logic [1:0]        policy_used;
    logic [RRPV_W-1:0] written_value;
  } rrip_out_t;

  typedef struct packed {
    logic             en;
    logic [SET_W-1:0] addr;
    rrip_row_t        data;
  } rrip_row_wr_t;

  typedef struct packed {
    logic              en;
    logic [PAGE_W-1:0] addr;
    logic [PCNT_W-1:0] data;
  } rrip_page_wr_t;

endpackage

// ===== hdl/rrip_rrpv_mem.sv =====
// rrpv row memory, one row of all ways per set, with per-row valid bits
`timescale 1ns / 1ps

module rrip_rrpv_mem (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       rd_en_i,
  input  logic [rrip_pkg::SET_W-1:0] rd_addr_i,
  output rrip_pkg::rrip_row_t        rd_data_o,
  input  rrip_pkg::rrip_row_wr_t     wr_i
);

  rrip_pkg::rrip_row_t mem_q [rrip_pkg::SETS];
  rrip_pkg::rrip_row_t rd_data_q;
  logic [rrip_pkg::SETS-1:0] row_valid_q;
  logic rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
      rd_valid_q  <= 1'b0;
    end else begin
      if (wr_i.en) begin
        row_valid_q[wr_i.addr] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= row_valid_q[rd_addr_i];
      end
    end
  end

  // a row never written reads as all zero
  assign rd_data_o = rd_valid_q ? rd_data_q : '0;

endmodule

// ===== hdl/rrip_page_mem.sv =====
// page use count memory with a clearing sweep after reset
`timescale 1ns / 1ps

module rrip_page_mem (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        rd_en_i,
  input  logic [rrip_pkg::PAGE_W-1:0] rd_addr_i,
  output logic [rrip_pkg::PCNT_W-1:0] rd_data_o,
  input  rrip_pkg::rrip_page_wr_t     wr_i,
  output logic                        busy_o
);

  logic [rrip_pkg::PCNT_W-1:0] mem_q [rrip_pkg::PAGES];
  logic [rrip_pkg::PCNT_W-1:0] rd_data_q;
  logic [rrip_pkg::PAGE_W-1:0] clr_idx_q;
  logic                        clr_busy_q;
  rrip_pkg::rrip_page_wr_t     wr;

  // the sweep owns the port until every page reads as unseen
  always_comb begin
    if (clr_busy_q) begin
      wr.en   = 1'b1;
      wr.addr = clr_idx_q;
      wr.data = '0;
    end else begin
      wr = wr_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr.en) begin
      mem_q[wr.addr] <= wr.data;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_idx_q  <= '0;
      clr_busy_q <= 1'b1;
    end else if (clr_busy_q) begin
      clr_idx_q <= clr_idx_q + 1'b1;
      if (clr_idx_q == rrip_pkg::PAGE_W'(rrip_pkg::PAGES - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  assign rd_data_o = rd_data_q;
  assign busy_o    = clr_busy_q;

endmodule

// ===== hdl/rrip_adaptive_replacement_top.sv =====
// top level: request sequencer, policy selection and victim search
`timescale 1ns / 1ps

// Adaptive RRIP replacement engine. On the accepting edge of a request
// the set's RRPV row and the page use entry are read from their
// synchronous memories; then, once the output register is free or drains,
// the row is written back with the insert value (or aged when no way has
// reached max), with the page count when the policy uses it, while the
// result is loaded into the output register. A new request is accepted only
// after the previous one has written back; a held result delays the
// write-back of the following request. After reset in_stall_o stays high
// while the page use table is swept clear; configuration writes are taken throughout.
module rrip_adaptive_replacement_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  rrip_pkg::rrip_in_t               in_req_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output rrip_pkg::rrip_out_t              out_rsp_o,
  input  logic                             cfg_we_i,
  input  logic [rrip_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [rrip_pkg::CNT_W-1:0]       cfg_data_i
);

  rrip_pkg::rrip_state_e state_q, state_d;
  rrip_pkg::rrip_in_t    req_q;
  rrip_pkg::rrip_out_t   out_q, out_d;
  logic                  out_valid_q, out_valid_d;

  logic [rrip_pkg::RRPV_W-1:0] max_q, instr_pos_q, data_pos_q;
  logic [rrip_pkg::CNT_W-1:0]  train_q;
  logic [rrip_pkg::SEL_W-1:0]  sel_q, sel_d;
  logic [rrip_pkg::CNT_W-1:0]  cnt_q, cnt_d;

  logic accept, proceed, page_busy;
  rrip_pkg::rrip_row_t     row, aged_row, upd_row;
  logic [rrip_pkg::PCNT_W-1:0] page_cnt;
  rrip_pkg::rrip_row_wr_t  row_wr;
  rrip_pkg::rrip_page_wr_t page_wr;

  logic                        found, page_used, hot, trained;
  logic [rrip_pkg::WAY_W-1:0]  first_max, pick;
  logic [rrip_pkg::RRPV_W-1:0] largest, add, fill, ins_i, ins_d, val;
  logic [1:0]                  policy;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != rrip_pkg::ST_IDLE) || page_busy;
  assign proceed    = (state_q == rrip_pkg::ST_EXEC) && (!out_valid_q || !out_stall_i);

  rrip_rrpv_mem u_rrpv_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_addr_i (in_req_i.set_index),
    .rd_data_o (row),
    .wr_i      (row_wr)
  );

  rrip_page_mem u_page_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_addr_i (in_req_i.page_number),
    .rd_data_o (page_cnt),
    .wr_i      (page_wr),
    .busy_o    (page_busy)
  );

  // victim search: first way at or above max, else age by max - largest
  always_comb begin
    found     = 1'b0;
    first_max = '0;
    for (int w = rrip_pkg::WAYS - 1; w >= 0; w--) begin
      if (row[w] >= max_q) begin
        found     = 1'b1;
        first_max = rrip_pkg::WAY_W'(w);
      end
    end
    largest = row[0];
    pick    = '0;
    for (int w = 1; w < rrip_pkg::WAYS; w++) begin
      if (row[w] > largest) begin
        largest = row[w];
        pick    = rrip_pkg::WAY_W'(w);
      end
    end
    add = max_q - largest;
    for (int w = 0; w < rrip_pkg::WAYS; w++) begin
      aged_row[w] = row[w] + add;
    end
  end

  // update path: counters, selector and insertion value
  always_comb begin
    cnt_d = (cnt_q != rrip_pkg::COUNT_SAT) ? cnt_q + 1'b1 : cnt_q;
    if (req_q.is_instruction) begin
      sel_d = (sel_q >= rrip_pkg::SEL_MAX) ? rrip_pkg::SEL_MAX : sel_q + 1'b1;
    end else begin
      sel_d = (sel_q == '0) ? '0 : sel_q - 1'b1;
    end
    trained = cnt_d > train_q;
    fill    = (max_q != '0) ? max_q - 1'b1 : '0;
    ins_i   = (max_q > instr_pos_q) ? max_q - instr_pos_q : '0;
    ins_d   = (max_q > data_pos_q) ? max_q - data_pos_q : '0;
    hot     = page_cnt >= rrip_pkg::PAGE_HOT;
    page_used = 1'b0;
    if (trained && sel_d <= rrip_pkg::SEL_DTP_HIGH) begin
      policy = rrip_pkg::POL_DTP;
      if (!req_q.is_instruction) begin
        page_used = 1'b1;
        val       = hot ? '0 : ins_d;
      end else begin
        val = req_q.is_hit ? ins_i : fill;
      end
    end else if (trained && sel_d >= rrip_pkg::SEL_ITP_LOW) begin
      policy = rrip_pkg::POL_ITP;
      if (req_q.is_instruction) begin
        page_used = 1'b1;
        val       = hot ? '0 : ins_i;
      end else begin
        val = req_q.is_hit ? ins_d : fill;
      end
    end else begin
      policy = rrip_pkg::POL_SRRIP;
      val    = req_q.is_hit ? '0 : fill;
    end
    upd_row = row;
    upd_row[req_q.way_index] = val;
  end

  // memory write-back and result
  always_comb begin
    row_wr.en    = 1'b0;
    row_wr.addr  = req_q.set_index;
    row_wr.data  = upd_row;
    page_wr.en   = 1'b0;
    page_wr.addr = req_q.page_number;
    page_wr.data = (page_cnt != rrip_pkg::PAGE_SAT) ? page_cnt + 1'b1 : page_cnt;
    out_d        = out_q;
    out_valid_d  = out_valid_q && out_stall_i;
    if (proceed) begin
      out_valid_d = 1'b1;
      if (req_q.op == rrip_pkg::OP_VICTIM) begin
        row_wr.en           = !found;
        row_wr.data         = aged_row;
        out_d.victim_way    = found ? first_max : pick;
        out_d.policy_used   = rrip_pkg::POL_VICTIM;
        out_d.written_value = '0;
      end else begin
        row_wr.en           = 1'b1;
        page_wr.en          = page_used;
        out_d.victim_way    = '0;
        out_d.policy_used   = policy;
        out_d.written_value = val;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rrip_pkg::ST_IDLE: begin
        if (accept) state_d = rrip_pkg::ST_EXEC;
      end
      rrip_pkg::ST_EXEC: begin
        if (proceed) state_d = rrip_pkg::ST_IDLE;
      end
      default: state_d = rrip_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rrip_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      sel_q       <= rrip_pkg::SEL_START;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (proceed && req_q.op == rrip_pkg::OP_UPDATE) begin
        sel_q <= sel_d;
        cnt_q <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q       <= rrip_pkg::MAX_RRPV_RESET;
      instr_pos_q <= '0;
      data_pos_q  <= '0;
      train_q     <= rrip_pkg::TRAIN_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rrip_pkg::CFG_MAX_RRPV:  max_q       <= cfg_data_i[rrip_pkg::RRPV_W-1:0];
        rrip_pkg::CFG_INSTR_POS: instr_pos_q <= cfg_data_i[rrip_pkg::RRPV_W-1:0];
        rrip_pkg::CFG_DATA_POS:  data_pos_q  <= cfg_data_i[rrip_pkg::RRPV_W-1:0];
        rrip_pkg::CFG_TRAINING:  train_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= in_req_i;
    end
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  a_accept_to_exec : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == rrip_pkg::ST_EXEC)
    else $error("accepted request did not start execution");

  a_sel_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sel_q <= rrip_pkg::SEL_MAX)
    else $error("selector out of range");

  a_victim_fields : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.policy_used == rrip_pkg::POL_VICTIM
      |-> out_rsp_o.written_value == '0)
    else $error("victim result carries a written value");

  a_update_fields : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.policy_used != rrip_pkg::POL_VICTIM
      |-> out_rsp_o.victim_way == '0 && out_rsp_o.written_value <= max_q)
    else $error("update result malformed");

  a_no_wb_while_clearing : assert property (@(posedge clk_i) disable iff (!rst_ni)
    page_busy |-> !proceed)
    else $error("write-back during page table sweep");

endmodule
